/* hw/rtl/pbl_pkg.sv */
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants of the periodic bell and lamp timer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbl_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECS_PER_MINUTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_MINUTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MINUTES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BELL_SECONDS    = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_DEBOUNCE_TICKS  = 8'd50;
  localparam logic [15:0] RST_TICKS_PER_SEC   = 16'd490;
  localparam logic [7:0]  RST_SECS_PER_MINUTE = 8'd60;
  localparam logic [7:0]  RST_LAMP_MINUTES    = 8'd5;
  localparam logic [7:0]  RST_CYCLE_MINUTES   = 8'd30;
  localparam logic [7:0]  RST_BELL_SECONDS    = 8'd10;

  // current register settings, handed from the register file to the core
  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] ticks_per_second;
    logic [7:0]  seconds_per_minute;
    logic [7:0]  lamp_minutes;
    logic [7:0]  cycle_minutes;
    logic [7:0]  bell_seconds;
  } cfg_t;

  // one result
  typedef struct packed {
    logic bell_relay;
    logic lamp_relay;
    logic led_level;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/pbl_ifs.sv */
// ----------------------------------------------------------------------------
// pbl_ifs
// Valid/ready channels of the timer: tick input and relay result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbl_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface pbl_result_if;
  logic valid;
  logic ready;
  logic bell_relay;
  logic lamp_relay;
  logic led_level;

  modport source (output valid, output bell_relay, output lamp_relay,
                  output led_level, input ready);
  modport sink   (input valid, input bell_relay, input lamp_relay,
                  input led_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pbl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pbl_cfg_regs
// Write-only register file holding the timer settings.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_cfg_regs
  import pbl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode one write; indexes past the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEBOUNCE_TICKS:  cfg_nxt.debounce_ticks     = cfg_wdata[7:0];
        REG_TICKS_PER_SEC:   cfg_nxt.ticks_per_second   = cfg_wdata[15:0];
        REG_SECS_PER_MINUTE: cfg_nxt.seconds_per_minute = cfg_wdata[7:0];
        REG_LAMP_MINUTES:    cfg_nxt.lamp_minutes       = cfg_wdata[7:0];
        REG_CYCLE_MINUTES:   cfg_nxt.cycle_minutes      = cfg_wdata[7:0];
        REG_BELL_SECONDS:    cfg_nxt.bell_seconds       = cfg_wdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= RST_DEBOUNCE_TICKS;
      cfg_r.ticks_per_second   <= RST_TICKS_PER_SEC;
      cfg_r.seconds_per_minute <= RST_SECS_PER_MINUTE;
      cfg_r.lamp_minutes       <= RST_LAMP_MINUTES;
      cfg_r.cycle_minutes      <= RST_CYCLE_MINUTES;
      cfg_r.bell_seconds       <= RST_BELL_SECONDS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/pbl_core.sv */
// ----------------------------------------------------------------------------
// pbl_core
// Timer state: debounce, tick/second/minute cascade and relay control.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_core
  import pbl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic step,          // one tick is processed this cycle
  input  wire logic button_level,
  output result_t   res            // relay and LED levels after this tick
);

  logic [7:0]  deb_cnt_r,   deb_cnt_nxt;
  logic [15:0] tick_cnt_r,  tick_cnt_nxt;
  logic [7:0]  sec_cnt_r,   sec_cnt_nxt;
  logic [7:0]  lamp_cnt_r,  lamp_cnt_nxt;
  logic [7:0]  cyc_cnt_r,   cyc_cnt_nxt;
  logic [7:0]  bell_cnt_r,  bell_cnt_nxt;
  logic        active_r,    active_nxt;
  logic        bell_r,      bell_nxt;
  logic        lamp_r,      lamp_nxt;
  logic        led_r,       led_nxt;

  logic [7:0]  deb_dec;
  logic [15:0] tick_dec;
  logic [7:0]  sec_dec, lamp_dec, cyc_dec, bell_dec;
  logic        press, sec_mark, min_mark, lamp_mark, cyc_mark;
  logic        bell_expire;

  // decrements of every counter
  assign deb_dec  = deb_cnt_r - 8'd1;
  assign tick_dec = tick_cnt_r - 16'd1;
  assign sec_dec  = sec_cnt_r - 8'd1;
  assign lamp_dec = lamp_cnt_r - 8'd1;
  assign cyc_dec  = cyc_cnt_r - 8'd1;
  assign bell_dec = bell_cnt_r - 8'd1;

  // event cascade
  assign press     = button_level && (deb_dec == 8'd0);
  assign sec_mark  = (tick_dec == 16'd0);
  assign min_mark  = sec_mark && (sec_dec == 8'd0);
  assign lamp_mark = min_mark && (lamp_dec == 8'd0);
  assign cyc_mark  = min_mark && (cyc_dec == 8'd0);

  // next state of one tick
  always_comb begin
    // debounce: reload when released or when a press fires
    deb_cnt_nxt  = (button_level && !press) ? deb_dec : cfg.debounce_ticks;

    tick_cnt_nxt = sec_mark ? cfg.ticks_per_second : tick_dec;
    led_nxt      = led_r ^ sec_mark;
    sec_cnt_nxt  = sec_cnt_r;
    lamp_cnt_nxt = lamp_cnt_r;
    cyc_cnt_nxt  = cyc_cnt_r;
    if (sec_mark) begin
      sec_cnt_nxt = min_mark ? cfg.seconds_per_minute : sec_dec;
    end
    if (min_mark) begin
      lamp_cnt_nxt = lamp_mark ? cfg.lamp_minutes : lamp_dec;
      cyc_cnt_nxt  = cyc_mark ? cfg.cycle_minutes : cyc_dec;
    end

    active_nxt   = active_r;
    bell_nxt     = bell_r;
    lamp_nxt     = lamp_r;
    bell_cnt_nxt = bell_cnt_r;
    bell_expire  = 1'b0;

    // cycle mark switches on and masks a lamp mark on the same tick
    if (cyc_mark) begin
      bell_nxt   = 1'b1;
      lamp_nxt   = 1'b1;
      active_nxt = 1'b1;
    end

    // per-second relay work
    if (sec_mark) begin
      if (lamp_mark && !cyc_mark && active_r) begin
        lamp_nxt   = 1'b0;
        active_nxt = 1'b0;
      end
      if (active_nxt) begin
        bell_expire  = (bell_dec == 8'd0);
        bell_cnt_nxt = bell_expire ? cfg.bell_seconds : bell_dec;
        if (bell_expire) begin
          bell_nxt = 1'b0;
        end
      end
    end

    // press reloads the cascade and drops both relays, active flag kept
    if (press) begin
      tick_cnt_nxt = cfg.ticks_per_second;
      sec_cnt_nxt  = cfg.seconds_per_minute;
      lamp_cnt_nxt = cfg.lamp_minutes;
      cyc_cnt_nxt  = cfg.cycle_minutes;
      bell_cnt_nxt = cfg.bell_seconds;
      bell_nxt     = 1'b0;
      lamp_nxt     = 1'b0;
    end
  end

  // counters reset from the register reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_cnt_r  <= RST_DEBOUNCE_TICKS;
      tick_cnt_r <= RST_TICKS_PER_SEC;
      sec_cnt_r  <= RST_SECS_PER_MINUTE;
      lamp_cnt_r <= RST_LAMP_MINUTES;
      cyc_cnt_r  <= RST_CYCLE_MINUTES;
      bell_cnt_r <= RST_BELL_SECONDS;
      active_r   <= 1'b0;
      bell_r     <= 1'b0;
      lamp_r     <= 1'b0;
      led_r      <= 1'b0;
    end else if (step) begin
      deb_cnt_r  <= deb_cnt_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      sec_cnt_r  <= sec_cnt_nxt;
      lamp_cnt_r <= lamp_cnt_nxt;
      cyc_cnt_r  <= cyc_cnt_nxt;
      bell_cnt_r <= bell_cnt_nxt;
      active_r   <= active_nxt;
      bell_r     <= bell_nxt;
      lamp_r     <= lamp_nxt;
      led_r      <= led_nxt;
    end
  end

  assign res.bell_relay = bell_nxt;
  assign res.lamp_relay = lamp_nxt;
  assign res.led_level  = led_nxt;

endmodule

`default_nettype wire

/* hw/rtl/periodic_bell_lamp_timer.sv */
// ----------------------------------------------------------------------------
// periodic_bell_lamp_timer
// Tick-driven bell and lamp relay timer with button debounce.
// ----------------------------------------------------------------------------
// Usage:
//   in_tick carries one transaction per timer tick with the sampled button
//   level. out_res returns exactly one transaction per tick: bell relay,
//   lamp relay and seconds LED levels after that tick.
//   The cfg_ port writes one setting per cycle while cfg_we is high; write
//   only while no tick is in flight.
// Pipeline and throughput:
//   A tick is captured in an input register, processed by the core and its
//   result is loaded into the output register, from which out_res.valid
//   rises. One tick per cycle is sustained while out_res is not stalled;
//   the state update is a single pass through the core between those
//   registers.
// Reset:
//   rst_n low (synchronous) restores the default settings, reloads all
//   counters, clears relays, LED and active flag and empties both stages.
//   in_tick.ready is low during reset.
// Stall:
//   While out_res is stalled the held result stays put and one more tick
//   can wait in the input register; then in_tick.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_bell_lamp_timer
  import pbl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pbl_tick_if.sink                   in_tick,
  pbl_result_if.source               out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t core_res;
  result_t res_r;
  logic    in_valid_r;
  logic    button_r;
  logic    out_valid_r;
  logic    advance;
  logic    step;
  logic    in_fire;

  pbl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: output register frees when empty or taken
  assign advance       = !out_valid_r || out_res.ready;
  assign step          = in_valid_r && advance;
  assign in_tick.ready = rst_n && (!in_valid_r || advance);
  assign in_fire       = in_tick.valid && in_tick.ready;

  pbl_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step         (step),
    .button_level (button_r),
    .res          (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      button_r <= in_tick.button_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= core_res;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.bell_relay = res_r.bell_relay;
  assign out_res.lamp_relay = res_r.lamp_relay;
  assign out_res.led_level  = res_r.led_level;

endmodule

`default_nettype wire

/* hw/rtl/pbl_checker.sv */
// ----------------------------------------------------------------------------
// pbl_checker
// Port-level checks of the timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbl_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_bell,
  input wire logic out_lamp,
  input wire logic out_led
);

  // held result stays valid until taken
  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // held result keeps its payload
  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bell) && $stable(out_lamp) && $stable(out_led))
    else $error("result payload changed while stalled");

  // input backs up only behind a stalled result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a fresh result rises only behind an accepted tick, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching tick");

endmodule

bind periodic_bell_lamp_timer pbl_checker u_pbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_tick.valid),
  .in_ready  (in_tick.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_bell  (out_res.bell_relay),
  .out_lamp  (out_res.lamp_relay),
  .out_led   (out_res.led_level)
);

`default_nettype wire

/* bench/periodic_bell_lamp_timer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_bell_lamp_timer_tb
// Checks the bell and lamp timer tick by tick. A scoreboard runs its own copy
// of the debounce and counter cascade on every accepted tick and compares the
// relay and LED levels it expects with each result transaction. Settings are
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------

// Predicts the relay and LED levels and holds them until the results arrive.
class relay_scoreboard;
  pbl_pkg::cfg_t    settings;
  logic [7:0]       debounce_cnt;
  logic [15:0]      tick_cnt;
  logic [7:0]       second_cnt;
  logic [7:0]       lamp_min_cnt;
  logic [7:0]       cycle_min_cnt;
  logic [7:0]       bell_cnt;
  logic             active;
  logic             bell;
  logic             lamp;
  logic             led;
  pbl_pkg::result_t expected_relays[$];
  int unsigned      errors;

  function new();
    errors = 0;
    restart();
  endfunction

  // state after reset: default settings, all counters reloaded
  function void restart();
    settings.debounce_ticks     = pbl_pkg::RST_DEBOUNCE_TICKS;
    settings.ticks_per_second   = pbl_pkg::RST_TICKS_PER_SEC;
    settings.seconds_per_minute = pbl_pkg::RST_SECS_PER_MINUTE;
    settings.lamp_minutes       = pbl_pkg::RST_LAMP_MINUTES;
    settings.cycle_minutes      = pbl_pkg::RST_CYCLE_MINUTES;
    settings.bell_seconds       = pbl_pkg::RST_BELL_SECONDS;
    debounce_cnt  = settings.debounce_ticks;
    tick_cnt      = settings.ticks_per_second;
    second_cnt    = settings.seconds_per_minute;
    lamp_min_cnt  = settings.lamp_minutes;
    cycle_min_cnt = settings.cycle_minutes;
    bell_cnt      = settings.bell_seconds;
    active = 1'b0;
    bell   = 1'b0;
    lamp   = 1'b0;
    led    = 1'b0;
    expected_relays.delete();
  endfunction

  // only the setting changes; counters pick it up at their next reload
  function void set_register(logic [pbl_pkg::CFG_IDX_W-1:0] idx,
                             logic [pbl_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      pbl_pkg::REG_DEBOUNCE_TICKS:  settings.debounce_ticks     = data[7:0];
      pbl_pkg::REG_TICKS_PER_SEC:   settings.ticks_per_second   = data;
      pbl_pkg::REG_SECS_PER_MINUTE: settings.seconds_per_minute = data[7:0];
      pbl_pkg::REG_LAMP_MINUTES:    settings.lamp_minutes       = data[7:0];
      pbl_pkg::REG_CYCLE_MINUTES:   settings.cycle_minutes      = data[7:0];
      pbl_pkg::REG_BELL_SECONDS:    settings.bell_seconds       = data[7:0];
      default: ;
    endcase
  endfunction

  // one accepted tick transaction
  function void note_tick(logic button);
    logic press;
    logic sec_mark;
    logic lamp_mark;
    logic cycle_mark;
    pbl_pkg::result_t res;
    press      = 1'b0;
    sec_mark   = 1'b0;
    lamp_mark  = 1'b0;
    cycle_mark = 1'b0;

    // debounce: a held button fires every debounce_ticks ticks
    if (button) begin
      debounce_cnt = debounce_cnt - 8'd1;
      if (debounce_cnt == 8'd0) begin
        debounce_cnt = settings.debounce_ticks;
        press = 1'b1;
      end
    end else begin
      debounce_cnt = settings.debounce_ticks;
    end

    // tick -> second -> minute -> lamp / cycle periods
    tick_cnt = tick_cnt - 16'd1;
    if (tick_cnt == 16'd0) begin
      led      = ~led;
      tick_cnt = settings.ticks_per_second;
      sec_mark = 1'b1;
      second_cnt = second_cnt - 8'd1;
      if (second_cnt == 8'd0) begin
        second_cnt   = settings.seconds_per_minute;
        lamp_min_cnt = lamp_min_cnt - 8'd1;
        if (lamp_min_cnt == 8'd0) begin
          lamp_min_cnt = settings.lamp_minutes;
          lamp_mark = 1'b1;
        end
        cycle_min_cnt = cycle_min_cnt - 8'd1;
        if (cycle_min_cnt == 8'd0) begin
          cycle_min_cnt = settings.cycle_minutes;
          cycle_mark = 1'b1;
        end
      end
    end

    // switch-on wins over a lamp mark on the same tick
    if (cycle_mark) begin
      bell      = 1'b1;
      lamp      = 1'b1;
      lamp_mark = 1'b0;
      active    = 1'b1;
    end

    if (sec_mark) begin
      if (lamp_mark && active) begin
        lamp   = 1'b0;
        active = 1'b0;
      end
      // bell countdown runs while active; it reloads on expiry or on a press
      if (active) begin
        bell_cnt = bell_cnt - 8'd1;
        if (bell_cnt == 8'd0) begin
          bell_cnt = settings.bell_seconds;
          bell     = 1'b0;
        end
      end
    end

    // press reloads everything and drops the relays, active flag untouched
    if (press) begin
      tick_cnt      = settings.ticks_per_second;
      second_cnt    = settings.seconds_per_minute;
      lamp_min_cnt  = settings.lamp_minutes;
      cycle_min_cnt = settings.cycle_minutes;
      bell_cnt      = settings.bell_seconds;
      bell = 1'b0;
      lamp = 1'b0;
    end

    res.bell_relay = bell;
    res.lamp_relay = lamp;
    res.led_level  = led;
    expected_relays.push_back(res);
  endfunction

  // one accepted result transaction
  function void check_result(pbl_pkg::result_t got);
    pbl_pkg::result_t exp;
    if (expected_relays.size() == 0) begin
      $error("result with no tick outstanding: bell %0b lamp %0b led %0b",
             got.bell_relay, got.lamp_relay, got.led_level);
      errors++;
      return;
    end
    exp = expected_relays.pop_front();
    if (got.bell_relay !== exp.bell_relay) begin
      $error("bell_relay: expected %0b, got %0b", exp.bell_relay, got.bell_relay);
      errors++;
    end
    if (got.lamp_relay !== exp.lamp_relay) begin
      $error("lamp_relay: expected %0b, got %0b", exp.lamp_relay, got.lamp_relay);
      errors++;
    end
    if (got.led_level !== exp.led_level) begin
      $error("led_level: expected %0b, got %0b", exp.led_level, got.led_level);
      errors++;
    end
  endfunction

  function int pending();
    return expected_relays.size();
  endfunction

  // results that never came
  function void flush_missing();
    if (expected_relays.size() != 0) begin
      $error("%0d result transactions missing", expected_relays.size());
      errors++;
      expected_relays.delete();
    end
  endfunction
endclass

module periodic_bell_lamp_timer_tb;
  import pbl_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pbl_tick_if   tick_ch ();
  pbl_result_if res_ch ();

  relay_scoreboard sb;
  int unsigned     burst_left;

  periodic_bell_lamp_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink: ready follows one of four stall modes, picked at random
  initial begin : result_sink
    int unsigned cyc;
    int unsigned mode;
    int unsigned run;
    cyc  = 0;
    mode = 0;
    run  = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        2: begin
          // long stretches of ready and stall
          if (run == 0) run = $urandom_range(1, 10);
          run--;
          res_ch.ready <= ((cyc / 8) % 2 == 0);
        end
        default: res_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_result({res_ch.bell_relay, res_ch.lamp_relay, res_ch.led_level});
  end

  // one tick transaction, then maybe a gap at the end of a burst
  task automatic send_tick(input logic button);
    int unsigned gap;
    tick_ch.valid        <= 1'b1;
    tick_ch.button_level <= button;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    sb.note_tick(button);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_level(input logic button, input int unsigned count);
    repeat (count) send_tick(button);
  endtask

  // wait for the block to go idle; missing results are reported
  task automatic settle();
    int unsigned n;
    n = 0;
    while (sb.pending() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    sb.flush_missing();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(REG_DEBOUNCE_TICKS,  {8'd0, s.debounce_ticks});
    write_reg(REG_TICKS_PER_SEC,   s.ticks_per_second);
    write_reg(REG_SECS_PER_MINUTE, {8'd0, s.seconds_per_minute});
    write_reg(REG_LAMP_MINUTES,    {8'd0, s.lamp_minutes});
    write_reg(REG_CYCLE_MINUTES,   {8'd0, s.cycle_minutes});
    write_reg(REG_BELL_SECONDS,    {8'd0, s.bell_seconds});
    cfg_we <= 1'b0;
  endtask

  // short periods so relay cycles happen often, now and then a longer one
  function automatic cfg_t random_settings();
    cfg_t s;
    s.debounce_ticks     = 8'($urandom_range(1, 6));
    s.ticks_per_second   = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 20))
                                                       : 16'($urandom_range(1, 3));
    s.seconds_per_minute = 8'($urandom_range(1, 3));
    s.lamp_minutes       = 8'($urandom_range(1, 4));
    s.cycle_minutes      = 8'($urandom_range(1, 5));
    s.bell_seconds       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 12))
                                                       : 8'($urandom_range(1, 4));
    return s;
  endfunction

  // idle runs let the cycle come round; holds around the debounce length
  // give short misses, single presses and repeats; some raw noise
  task automatic random_ticks(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    int unsigned deb;
    sent = 0;
    deb  = (sb.settings.debounce_ticks == 0) ? 256 : sb.settings.debounce_ticks;
    while (sent < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        len = $urandom_range(1, 40);
        send_level(1'b0, len);
      end else if (kind < 17) begin
        len = $urandom_range((deb > 1) ? deb - 1 : 1, 2 * deb + 1);
        send_level(1'b1, len);
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_tick(1'($urandom_range(0, 1)));
      end
      sent += len;
    end
  endtask

  // stimulus
  initial begin : stimulus
    cfg_t s;
    logic [24:0] pattern;
    sb = new();
    burst_left = 1;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_wdata            <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.button_level <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: near miss, press, held repeat, switch-on, press while active
    s.debounce_ticks     = 8'd3;
    s.ticks_per_second   = 16'd1;
    s.seconds_per_minute = 8'd2;
    s.lamp_minutes       = 8'd3;
    s.cycle_minutes      = 8'd2;
    s.bell_seconds       = 8'd2;
    apply_settings(s);
    pattern = 25'b110_111_111_00000000_111_00000;
    for (int i = 24; i >= 0; i--) send_tick(pattern[i]);
    tick_ch.valid <= 1'b0;
    settle();

    // smallest settings: every tick is a minute, lamp and cycle marks collide
    s.debounce_ticks     = 8'd1;
    s.ticks_per_second   = 16'd1;
    s.seconds_per_minute = 8'd1;
    s.lamp_minutes       = 8'd1;
    s.cycle_minutes      = 8'd1;
    s.bell_seconds       = 8'd1;
    apply_settings(s);
    random_ticks(120);
    tick_ch.valid <= 1'b0;
    settle();

    // largest settings: a hold past the full debounce length, then random ticks
    s.debounce_ticks     = 8'd255;
    s.ticks_per_second   = 16'd65535;
    s.seconds_per_minute = 8'd255;
    s.lamp_minutes       = 8'd255;
    s.cycle_minutes      = 8'd255;
    s.bell_seconds       = 8'd255;
    apply_settings(s);
    send_level(1'b1, 260);
    send_level(1'b0, 10);
    random_ticks(40);
    tick_ch.valid <= 1'b0;
    settle();

    // random settings, counters carry over between phases
    repeat (7) begin
      apply_settings(random_settings());
      random_ticks(210);
      tick_ch.valid <= 1'b0;
      settle();
    end

    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* periodic_bell_lamp_timer.f */
hw/rtl/pbl_pkg.sv
hw/rtl/pbl_ifs.sv
hw/rtl/pbl_cfg_regs.sv
hw/rtl/pbl_core.sv
hw/rtl/periodic_bell_lamp_timer.sv
hw/rtl/pbl_checker.sv
bench/periodic_bell_lamp_timer_tb.sv
